### rtl/rbch_pkg.sv
// rbch_pkg: shared types, constants and codes for the ray/box closest-hit core
// no dependencies
package rbch_pkg;

  localparam int unsigned EntityBitsDef = 16;
  localparam int unsigned CoordW        = 32;
  localparam int unsigned DistW         = 31;
  localparam int unsigned NumAxes       = 3;
  localparam int unsigned DivSteps      = 49;
  localparam int unsigned DivCntW       = 6;

  localparam logic [DistW-1:0] DistMax = '1;

  // register index codes
  typedef enum logic [2:0] {
    REG_ORG_X = 3'd0,
    REG_ORG_Y = 3'd1,
    REG_ORG_Z = 3'd2,
    REG_DIR_X = 3'd3,
    REG_DIR_Y = 3'd4,
    REG_DIR_Z = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [15:0]       entity_id;
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_min_z;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
    logic signed [31:0] box_max_z;
    logic               last_box;
  } box_word_t;

  typedef struct packed {
    logic        hit_found;
    logic [15:0] hit_entity;
    logic [30:0] hit_distance;
  } hit_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_AXIS,
    ST_MERGE,
    ST_OUT
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic div_start;
    logic axis_sel;
    logic merge;
    logic emit;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic last;
  } dp_status_t;

endpackage

### rtl/rbch_div.sv
// rbch_div: iterative restoring signed divider, one quotient bit per cycle
// depends on rbch_pkg
module rbch_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [48:0]               num_i,
  input  logic signed [31:0]               den_i,
  output logic                             done_o,
  output logic signed [31:0]               quo_o
);
  import rbch_pkg::*;

  logic [48:0]        rem_q, rem_d;
  logic [48:0]        quo_q, quo_d;
  logic [32:0]        den_q, den_d;
  logic               neg_q, neg_d;
  logic               busy_q, busy_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [49:0]        trial;
  logic [48:0]        qs;
  logic signed [49:0] qsgn;

  // magnitude handled unsigned, sign restored at end
  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    neg_d  = neg_q;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    trial  = {rem_q, quo_q[48]} - {17'd0, den_q};
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i[48] ? 49'(-num_i) : num_i;
      den_d  = den_i[31] ? 33'(-{den_i[31], den_i}) : {1'b0, den_i};
      neg_d  = num_i[48] ^ den_i[31];
      busy_d = 1'b1;
      cnt_d  = DivCntW'(DivSteps);
    end else if (busy_q) begin
      if (!trial[49]) begin
        rem_d = trial[48:0];
        quo_d = {quo_q[47:0], 1'b1};
      end else begin
        rem_d = {rem_q[47:0], quo_q[48]};
        quo_d = {quo_q[47:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DivCntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  // sign fix and saturation to 32 bits
  always_comb begin
    qs   = quo_q;
    qsgn = neg_q ? -$signed({1'b0, qs}) : $signed({1'b0, qs});
    if (qsgn > 50'sd2147483647)       quo_o = 32'sh7fffffff;
    else if (qsgn < -50'sd2147483648) quo_o = 32'sh80000000;
    else                              quo_o = qsgn[31:0];
  end

  assign done_o = ~busy_q;
endmodule

### rtl/rbch_ctrl.sv
// rbch_ctrl: sequencing state machine for one box
// depends on rbch_pkg
module rbch_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  rbch_pkg::dp_status_t   status_i,
  output rbch_pkg::ctrl_cmd_t    cmd_o
);
  import rbch_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        ph_q, ph_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ph_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
    end
  end

  // next state: two division rounds (min planes, then max planes)
  always_comb begin
    state_d = state_q;
    ph_d    = ph_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) begin
        state_d = ST_DIV;
        ph_d    = 1'b0;
      end
      ST_DIV: state_d = ST_AXIS;
      ST_AXIS: if (status_i.div_done) begin
        if (!ph_q) begin
          ph_d    = 1'b1;
          state_d = ST_DIV;
        end else begin
          state_d = ST_MERGE;
        end
      end
      ST_MERGE: state_d = status_i.last ? ST_OUT : ST_IDLE;
      ST_OUT: if (out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_DIV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.axis_sel  = ph_q;
      end
      ST_AXIS: cmd_o.axis_sel = ph_q;
      ST_MERGE: begin
        cmd_o.merge = 1'b1;
        cmd_o.emit  = status_i.last;
      end
      ST_OUT: out_valid_o = 1'b1;
      default: ;
    endcase
  end
endmodule

### rtl/rbch_dp.sv
// rbch_dp: ray registers, three divider lanes, slab fold and best-hit state
// depends on rbch_pkg, rbch_div
module rbch_dp #(
  parameter int unsigned EntityBits = rbch_pkg::EntityBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [2:0]            cfg_index_i,
  input  logic [31:0]           cfg_data_i,
  input  rbch_pkg::box_word_t   box_i,
  input  rbch_pkg::ctrl_cmd_t   cmd_i,
  output rbch_pkg::dp_status_t  status_o,
  output rbch_pkg::hit_word_t   hit_o
);
  import rbch_pkg::*;

  logic signed [31:0] org_q [NumAxes];
  logic signed [31:0] dir_q [NumAxes];
  logic signed [31:0] bmin_q [NumAxes];
  logic signed [31:0] bmax_q [NumAxes];
  logic signed [31:0] t1_q [NumAxes];
  logic [EntityBits-1:0] ent_q;
  logic               last_q;
  logic [DistW-1:0]   best_dist_q;
  logic [EntityBits-1:0] best_ent_q;
  logic               any_q;
  logic [NumAxes-1:0] done;
  logic signed [31:0] quo [NumAxes];
  logic signed [48:0] num [NumAxes];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NumAxes; a++) begin
        org_q[a] <= '0;
        dir_q[a] <= '0;
      end
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_ORG_X: org_q[0] <= cfg_data_i;
        REG_ORG_Y: org_q[1] <= cfg_data_i;
        REG_ORG_Z: org_q[2] <= cfg_data_i;
        REG_DIR_X: dir_q[0] <= cfg_data_i;
        REG_DIR_Y: dir_q[1] <= cfg_data_i;
        REG_DIR_Z: dir_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // box capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bmin_q[0] <= box_i.box_min_x;
      bmin_q[1] <= box_i.box_min_y;
      bmin_q[2] <= box_i.box_min_z;
      bmax_q[0] <= box_i.box_max_x;
      bmax_q[1] <= box_i.box_max_y;
      bmax_q[2] <= box_i.box_max_z;
      ent_q     <= EntityBits'(box_i.entity_id);
      last_q    <= box_i.last_box;
    end
  end

  // divider lanes: one per axis, min planes first then max planes
  for (genvar a = 0; a < NumAxes; a++) begin : g_lane
    logic signed [32:0] diff;
    assign diff = cmd_i.axis_sel
                ? 33'($signed(bmax_q[a])) - 33'($signed(org_q[a]))
                : 33'($signed(bmin_q[a])) - 33'($signed(org_q[a]));
    assign num[a] = {diff, 16'd0};
    rbch_div u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .start_i(cmd_i.div_start),
      .num_i  (num[a]),
      .den_i  (dir_q[a]),
      .done_o (done[a]),
      .quo_o  (quo[a])
    );
    always_ff @(posedge clk_i) begin
      if (cmd_i.div_start && cmd_i.axis_sel == 1'b1) t1_q[a] <= quo[a];
    end
  end

  assign status_o.div_done = &done;
  assign status_o.last     = last_q;

  // slab fold: all axes in sequence, narrow compares
  logic signed [32:0] t_in, t_out, lo, hi;
  logic               miss;
  always_comb begin
    t_in  = '0;
    t_out = 33'sd2147483647;
    miss  = 1'b0;
    lo    = '0;
    hi    = '0;
    for (int a = 0; a < NumAxes; a++) begin
      if (dir_q[a] != '0) begin
        lo = (t1_q[a] > quo[a]) ? 33'(quo[a]) : 33'(t1_q[a]);
        hi = (t1_q[a] > quo[a]) ? 33'(t1_q[a]) : 33'(quo[a]);
        if (lo > t_in)  t_in  = lo;
        if (hi < t_out) t_out = hi;
        if (t_out < t_in) miss = 1'b1;
      end else if (org_q[a] < bmin_q[a] || org_q[a] > bmax_q[a]) begin
        miss = 1'b1;
      end
    end
  end

  // best hit tracking, cleared when the last box of a trace is merged
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_dist_q <= DistMax;
      best_ent_q  <= '0;
      any_q       <= 1'b0;
    end else if (cmd_i.merge) begin
      if (cmd_i.emit) begin
        best_dist_q <= DistMax;
        best_ent_q  <= '0;
        any_q       <= 1'b0;
      end else if (!miss && (!any_q || t_in[DistW-1:0] < best_dist_q)) begin
        best_dist_q <= t_in[DistW-1:0];
        best_ent_q  <= ent_q;
        any_q       <= 1'b1;
      end
    end
  end

  // result register, trace state cleared when captured
  hit_word_t hit_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      if (!miss && (!any_q || t_in[DistW-1:0] < best_dist_q)) begin
        hit_q.hit_found    <= 1'b1;
        hit_q.hit_entity   <= 16'(ent_q);
        hit_q.hit_distance <= t_in[DistW-1:0];
      end else begin
        hit_q.hit_found    <= any_q;
        hit_q.hit_entity   <= 16'(best_ent_q);
        hit_q.hit_distance <= best_dist_q;
      end
    end
  end
  assign hit_o = hit_q;
endmodule

### rtl/ray_box_closest_hit_core.sv
// ray_box_closest_hit_core: top level of the ray/box closest-hit core
// depends on rbch_pkg, rbch_ctrl, rbch_dp
// Write the ray origin and direction (signed Q16.16) over the configuration port while no
// box is in flight, then stream boxes; the word marked last_box returns one result with the
// nearest hit (first box wins ties). Each box runs two rounds of 49-step dividers in three
// axis lanes (min planes, then max planes): the box is accepted, each round starts the
// dividers and waits for them, and the box is merged; no new box is taken until then. On the
// last box the result is registered at the merge; the input stays stalled until it is taken.
module ray_box_closest_hit_core #(
  parameter int unsigned EntityBits = rbch_pkg::EntityBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rbch_pkg::box_word_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rbch_pkg::hit_word_t out_data_o
);
  import rbch_pkg::*;
  ctrl_cmd_t  cmd;
  dp_status_t status;
  assign cfg_ready_o = 1'b1;
  rbch_ctrl u_ctrl (.clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o,
    .out_ready_i, .status_i(status), .cmd_o(cmd));
  rbch_dp #(.EntityBits(EntityBits)) u_dp (.clk_i, .rst_ni, .cfg_valid_i,
    .cfg_index_i, .cfg_data_i, .box_i(in_data_i), .cmd_i(cmd),
    .status_o(status), .hit_o(out_data_o));
endmodule

// rbch_checker: port-level protocol checks, bound to ray_box_closest_hit_core
module rbch_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input rbch_pkg::hit_word_t out_data_o
);
  // result word held until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o));

  // no input taken while a result waits
  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o);

  // one box at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o);

  // a miss reports entity zero and the maximum distance
  a_miss_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.hit_found |->
      out_data_o.hit_entity == '0 && &out_data_o.hit_distance);
endmodule

bind ray_box_closest_hit_core rbch_checker u_checker (.*);
